@@ rtl/rpfs_pkg.sv @@
package rpfs_pkg;

    localparam int COLS_DEF      = 16;
    localparam int ROWS_DEF      = 9;
    localparam int CHUNK_LEN_DEF = 24;

    localparam int POS_W   = 16;
    localparam int COLOR_W = 16;
    localparam int CHUNK_W = 3;
    localparam int LEVEL_W = 8;
    localparam int LIDX_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] BRIGHTNESS_RST   = 8'd255;
    localparam logic [4:0] PANEL_WIDTH_RST  = 5'd16;
    localparam logic [3:0] PANEL_HEIGHT_RST = 4'd9;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_PUSH  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS   = 2'd0,
        CFG_ROTATION     = 2'd1,
        CFG_PANEL_WIDTH  = 2'd2,
        CFG_PANEL_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUSH
    } state_t;

endpackage

@@ rtl/rpfs_if.sv @@
interface rpfs_cmd_if
    import rpfs_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0]        color;
    logic [CHUNK_W-1:0]        chunk;

    modport source (output valid, opcode, pos_x, pos_y, color, chunk, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, color, chunk, output ready);
endinterface

interface rpfs_led_if
    import rpfs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LIDX_W-1:0]  led_index;
    logic [LEVEL_W-1:0] level;
    logic               last;

    modport source (output valid, led_index, level, last, input ready);
    modport sink   (input valid, led_index, level, last, output ready);
endinterface

interface rpfs_cfg_if
    import rpfs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rpfs_ram.sv @@
module rpfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 144,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rotated_pixel_framebuffer_scaler_top.sv @@
// LED framebuffer of COLS x ROWS 8-bit levels held in one single-port-write RAM.
// A draw beat rotates its position by the configured quarter turn, drops it if
// off the panel, and writes the colour clamped to 255. After reset and after
// every clear beat the store is swept to zero, one entry a cycle, during which
// no command is taken; config writes are always taken. A push beat streams its
// chunk (up to CHUNK_LEN entries) one entry a cycle while the LED port is not
// stalled, from the RAM read port, each level scaled by brightness/255 and
// floored, the final entry flagged by last; the next command is taken once the
// final read has been issued.
module rotated_pixel_framebuffer_scaler_top
    import rpfs_pkg::*;
#(
    parameter int COLS      = COLS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int CHUNK_LEN = CHUNK_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rpfs_cmd_if.sink   cmd,
    rpfs_led_if.source led,
    rpfs_cfg_if.sink   cfg
);

    localparam int STORE_SIZE = COLS * ROWS;
    localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int SUM_W      = $clog2(STORE_SIZE + 8 * CHUNK_LEN + 1);

    state_t state_reg, state_next;

    logic [7:0] brightness_reg;
    rot_t       rotation_reg;
    logic [4:0] panel_width_reg;
    logic [3:0] panel_height_reg;

    logic [AW-1:0]    clr_reg, clr_next;
    logic [SUM_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] end_reg, end_next;

    logic             s1_valid_reg, s1_valid_next;
    logic [SUM_W-1:0] s1_idx_reg;
    logic             s1_last_reg;

    logic               out_valid_reg;
    logic [LIDX_W-1:0]  out_idx_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_last_reg;

    logic cmd_fire, out_free, s1_move, issue;

    // draw path
    logic [POS_W-1:0] px, py, rx, ry, pw16, ph16;
    logic [31:0]      lin_addr;
    logic             on_panel;
    logic [7:0]       clamped;

    // push path
    logic [SUM_W-1:0] base, chunk_end;

    // ram
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    logic [15:0] prod;
    logic [16:0] quot;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg   <= BRIGHTNESS_RST;
            rotation_reg     <= ROT_0;
            panel_width_reg  <= PANEL_WIDTH_RST;
            panel_height_reg <= PANEL_HEIGHT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_BRIGHTNESS:   brightness_reg   <= cfg.data;
                CFG_ROTATION:     rotation_reg     <= rot_t'(cfg.data[1:0]);
                CFG_PANEL_WIDTH:  panel_width_reg  <= cfg.data[4:0];
                CFG_PANEL_HEIGHT: panel_height_reg <= cfg.data[3:0];
                default:          ;
            endcase
        end
    end

    assign px   = cmd.pos_x;
    assign py   = cmd.pos_y;
    assign pw16 = POS_W'(panel_width_reg);
    assign ph16 = POS_W'(panel_height_reg);

    always_comb
    begin
        case (rotation_reg)
            ROT_90:
            begin
                rx = pw16 - py - 16'd1;
                ry = px;
            end
            ROT_180:
            begin
                rx = pw16 - px - 16'd1;
                ry = ph16 - py - 16'd1;
            end
            ROT_270:
            begin
                rx = py;
                ry = ph16 - px - 16'd1;
            end
            default:
            begin
                rx = px;
                ry = py;
            end
        endcase
    end

    assign on_panel = (32'(rx) < 32'(COLS)) && (32'(ry) < 32'(ROWS));
    assign lin_addr = 32'(rx) + 32'(ry) * 32'(COLS);
    assign clamped  = (|cmd.color[COLOR_W-1:8]) ? 8'd255 : cmd.color[7:0];

    assign base      = SUM_W'(cmd.chunk) * SUM_W'(CHUNK_LEN);
    assign chunk_end = (base + SUM_W'(CHUNK_LEN) > SUM_W'(STORE_SIZE))
                     ? SUM_W'(STORE_SIZE) : base + SUM_W'(CHUNK_LEN);

    assign out_free = !out_valid_reg || led.ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign issue    = (state_reg == ST_PUSH) && (!s1_valid_reg || s1_move);

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        s1_valid_next = s1_move ? 1'b0 : s1_valid_reg;
        we            = 1'b0;
        waddr         = clr_reg;
        wdata         = 8'd0;
        re            = 1'b0;
        raddr         = idx_reg[AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(STORE_SIZE - 1))
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (op_t'(cmd.opcode))
                        OP_DRAW:
                        begin
                            we    = on_panel;
                            waddr = lin_addr[AW-1:0];
                            wdata = clamped;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        OP_PUSH:
                        begin
                            if (base < SUM_W'(STORE_SIZE))
                            begin
                                idx_next   = base;
                                end_next   = chunk_end;
                                state_next = ST_PUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PUSH:
            begin
                if (issue)
                begin
                    re            = 1'b1;
                    s1_valid_next = 1'b1;
                    idx_next      = idx_reg + SUM_W'(1);
                    if (idx_reg + SUM_W'(1) == end_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            end_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            idx_reg      <= idx_next;
            end_reg      <= end_next;
            s1_valid_reg <= s1_valid_next;
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_idx_reg  <= idx_reg;
            s1_last_reg <= (idx_reg + SUM_W'(1) == end_reg);
        end
        if (s1_move)
        begin
            out_idx_reg   <= LIDX_W'(s1_idx_reg);
            out_level_reg <= quot[15:8];
            out_last_reg  <= s1_last_reg;
        end
    end

    // floor(p/255) for p up to 255*255, the largest product
    assign prod = 16'(rdata) * 16'(brightness_reg);
    assign quot = 17'(prod) + 17'(prod[15:8]) + 17'd1;

    rpfs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign led.valid     = out_valid_reg;
    assign led.led_index = out_idx_reg;
    assign led.level     = out_level_reg;
    assign led.last      = out_last_reg;

`ifndef SYNTHESIS
    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> $stable(rdata))
        else $error("read data changed under a stalled entry");

    a_push_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH |-> idx_reg < end_reg && end_reg <= SUM_W'(STORE_SIZE))
        else $error("push index outside its chunk");

    a_no_write_in_push: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH |-> !we)
        else $error("store written while a chunk is read");
`endif

endmodule
